### rtl/mqttu_pkg.sv
package mqttu_pkg;

    localparam int LENGTH_BITS_DEFAULT = 28;

    typedef enum logic [1:0] {
        PH_ID  = 2'd0,
        PH_LEN = 2'd1,
        PH_VAL = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        EV_ABSORB = 3'd0,
        EV_ID     = 3'd1,
        EV_LEN    = 3'd2,
        EV_BYTE   = 3'd3,
        EV_IGNORE = 3'd4
    } event_t;

    typedef enum logic [1:0] {
        ERR_NONE       = 2'd0,
        ERR_NO_PAYLOAD = 2'd1,
        ERR_ZERO_LEN   = 2'd2,
        ERR_OVERRUN    = 2'd3
    } err_t;

    // parser state apart from the length-wide consumed count
    typedef struct packed {
        phase_t      phase;
        logic        field_byte_count;
        logic [7:0]  high_byte_hold;
        logic [15:0] topic_bytes_left;
        logic [15:0] ident;
        logic [15:0] topic_len;
        logic [15:0] topic_counter;
        logic        finished;
        err_t        err;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{
        phase:            PH_ID,
        field_byte_count: 1'b0,
        high_byte_hold:   8'd0,
        topic_bytes_left: 16'd0,
        ident:            16'd0,
        topic_len:        16'd0,
        topic_counter:    16'd0,
        finished:         1'b0,
        err:              ERR_NONE
    };

    typedef struct packed {
        event_t      event_kind;
        logic [15:0] packet_ident;
        logic [15:0] topic_length;
        logic [7:0]  topic_byte;
        logic        topic_last;
        logic [15:0] topic_index;
        logic        packet_done;
        err_t        error_code;
    } parse_result_t;

endpackage

### rtl/mqttu_step.sv
module mqttu_step
    import mqttu_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
    input  parse_state_t           state_cur,
    input  logic [LENGTH_BITS-1:0] consumed_cur,
    input  logic [LENGTH_BITS-1:0] rem_len,
    input  logic [7:0]             data_byte,
    output parse_state_t           state_nxt,
    output logic [LENGTH_BITS-1:0] consumed_nxt,
    output parse_result_t          result
);

    localparam logic [LENGTH_BITS-1:0] CONSUMED_MAX = '1;

    logic [LENGTH_BITS-1:0] consumed_bump;
    logic                   body_used;
    logic [15:0]            field_word;
    logic [15:0]            left_dec;
    event_t                 kind;
    logic [7:0]             tbyte;
    logic                   tlast;

    assign consumed_bump = (consumed_cur == CONSUMED_MAX) ? consumed_cur
                                                          : consumed_cur + 1'b1;
    assign body_used     = (consumed_bump >= rem_len);
    assign field_word    = {state_cur.high_byte_hold, data_byte};
    assign left_dec      = (state_cur.topic_bytes_left != 16'd0)
                           ? state_cur.topic_bytes_left - 16'd1 : 16'd0;

    always_comb begin
        state_nxt    = state_cur;
        consumed_nxt = consumed_cur;
        kind         = EV_ABSORB;
        tbyte        = 8'd0;
        tlast        = 1'b0;
        if (state_cur.finished || (state_cur.err != ERR_NONE)) begin
            kind = EV_IGNORE;
        end else begin
            unique case (state_cur.phase)
                PH_ID: begin
                    consumed_nxt = consumed_bump;
                    if (!state_cur.field_byte_count) begin
                        state_nxt.high_byte_hold   = data_byte;
                        state_nxt.field_byte_count = 1'b1;
                    end else begin
                        state_nxt.field_byte_count = 1'b0;
                        state_nxt.ident            = field_word;
                        kind                       = EV_ID;
                        if (body_used) begin
                            state_nxt.err = ERR_NO_PAYLOAD;
                        end else begin
                            state_nxt.phase = PH_LEN;
                        end
                    end
                end
                PH_LEN: begin
                    consumed_nxt = consumed_bump;
                    if (!state_cur.field_byte_count) begin
                        state_nxt.high_byte_hold   = data_byte;
                        state_nxt.field_byte_count = 1'b1;
                    end else begin
                        state_nxt.field_byte_count = 1'b0;
                        state_nxt.topic_len        = field_word;
                        kind                       = EV_LEN;
                        // zero length wins over overrun
                        if (field_word == 16'd0) begin
                            state_nxt.err = ERR_ZERO_LEN;
                        end else if (body_used) begin
                            state_nxt.err = ERR_OVERRUN;
                        end else begin
                            state_nxt.topic_bytes_left = field_word;
                            state_nxt.phase            = PH_VAL;
                        end
                    end
                end
                PH_VAL: begin
                    consumed_nxt               = consumed_bump;
                    kind                       = EV_BYTE;
                    tbyte                      = data_byte;
                    state_nxt.topic_bytes_left = left_dec;
                    if (left_dec == 16'd0) begin
                        tlast = 1'b1;
                        if (state_cur.topic_counter != 16'hFFFF) begin
                            state_nxt.topic_counter = state_cur.topic_counter + 16'd1;
                        end
                        if (body_used) begin
                            state_nxt.finished = 1'b1;
                        end else begin
                            state_nxt.phase = PH_LEN;
                        end
                    end
                end
                default: begin
                    kind = EV_IGNORE;
                end
            endcase
        end
    end

    always_comb begin
        result.event_kind   = kind;
        result.packet_ident = state_nxt.ident;
        result.topic_length = state_nxt.topic_len;
        result.topic_byte   = tbyte;
        result.topic_last   = tlast;
        result.topic_index  = state_cur.topic_counter;
        result.packet_done  = state_nxt.finished;
        result.error_code   = state_nxt.err;
    end

endmodule

### rtl/mqtt_unsubscribe_body_parser.sv
// mqtt unsubscribe body parser
//
// s_ channel: one body byte (everything after the fixed header) per transfer
// m_ channel: one event per accepted byte, in order
// cfg_we / cfg_wdata: remaining length of the body; a write rearms the parser
//   for a new packet; the user makes it only while no transfer is in flight,
//   and the block does not enforce this
// latency: the event for a byte is registered at the edge that accepts the
//   byte and is offered on the m_ side from the next cycle on
// throughput: one byte per cycle unless the receiver stalls; the parser state
//   updates in one pass of the step logic between state and output registers
//
// reset (aresetn low, synchronous) clears the parser state, the body length
//   and the output valid flag
// when the receiver stalls the output register holds its event and s_tready
//   drops until m_tready returns; s_tready is high whenever the output
//   register is empty or is being emptied in the same cycle
// after packet done or an error every byte gives an ignored event until the
//   body length is written again
module mqtt_unsubscribe_body_parser
    import mqttu_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   cfg_we,
    input  logic [LENGTH_BITS-1:0] cfg_wdata,   // body_length

    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,     // [7:0] data_byte

    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [15:0] packet_ident, [31:16] topic_length, [39:32] topic_byte,
    // [55:40] topic_index, [56] packet_done, [58:57] error_code, [63:59] zero
    output logic [63:0]            m_tdata,
    output logic [2:0]             m_tuser,     // [2:0] event_kind
    output logic                   m_tlast      // topic_last
);

    // parser state
    parse_state_t           state_reg;
    parse_state_t           state_next;
    logic [LENGTH_BITS-1:0] consumed_reg;
    logic [LENGTH_BITS-1:0] consumed_next;
    logic [LENGTH_BITS-1:0] rem_len_reg;

    // output register
    logic                   out_valid_reg;
    parse_result_t          out_reg;
    parse_result_t          step_result;

    logic                   in_xfer;

    // output register frees up when empty or when its event is taken
    assign s_tready = !out_valid_reg || m_tready;
    assign in_xfer  = s_tvalid && s_tready;

    mqttu_step #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_step (
        .state_cur    (state_reg),
        .consumed_cur (consumed_reg),
        .rem_len      (rem_len_reg),
        .data_byte    (s_tdata),
        .state_nxt    (state_next),
        .consumed_nxt (consumed_next),
        .result       (step_result)
    );

    // state registers; a length write rearms the parser
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= STATE_RESET;
            consumed_reg <= '0;
            rem_len_reg  <= '0;
        end else if (cfg_we) begin
            state_reg    <= STATE_RESET;
            consumed_reg <= '0;
            rem_len_reg  <= cfg_wdata;
        end else if (in_xfer) begin
            state_reg    <= state_next;
            consumed_reg <= consumed_next;
        end
    end

    // output valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_xfer) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // output payload, no reset needed
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            out_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.event_kind;
    assign m_tlast  = out_reg.topic_last;
    assign m_tdata  = {5'd0,
                       out_reg.error_code,
                       out_reg.packet_done,
                       out_reg.topic_index,
                       out_reg.topic_byte,
                       out_reg.topic_length,
                       out_reg.packet_ident};

    // an error is reported only with the field that raised it or afterwards
    a_err_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (out_reg.error_code != ERR_NONE)) |->
        ((out_reg.event_kind == EV_ID) || (out_reg.event_kind == EV_LEN) ||
         (out_reg.event_kind == EV_IGNORE)))
        else $error("error reported with a byte or absorb event");

    // topic byte and last mark only on topic byte events
    a_byte_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (out_reg.event_kind != EV_BYTE)) |->
        ((out_reg.topic_byte == 8'd0) && !out_reg.topic_last))
        else $error("topic byte or last mark outside a topic byte event");

    // a sticky error stays until the length is written again
    a_err_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg.err != ERR_NONE) && !cfg_we) |=>
        (state_reg.err == $past(state_reg.err)))
        else $error("sticky error changed without a rearm");

    // once finished, bytes no longer advance the consumed count
    a_done_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.finished && !cfg_we) |=> $stable(consumed_reg))
        else $error("consumed count moved after packet done");

endmodule
